@@ hw/rtl/alist_pkg.sv @@
// Shared types and constants of the array list engine.
`default_nettype none

package alist_pkg;

    // Field widths of a command and of a response
    localparam int OPC_W = 4;
    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int ST_W  = 3;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    // Command opcodes
    localparam logic [OPC_W-1:0] OP_CLEAR     = 4'd0;
    localparam logic [OPC_W-1:0] OP_APPEND    = 4'd1;
    localparam logic [OPC_W-1:0] OP_INS_FRONT = 4'd2;
    localparam logic [OPC_W-1:0] OP_INS_AT    = 4'd3;
    localparam logic [OPC_W-1:0] OP_DEL_FRONT = 4'd4;
    localparam logic [OPC_W-1:0] OP_DEL_END   = 4'd5;
    localparam logic [OPC_W-1:0] OP_DEL_AT    = 4'd6;
    localparam logic [OPC_W-1:0] OP_READ      = 4'd7;
    localparam logic [OPC_W-1:0] OP_SEARCH    = 4'd8;
    localparam logic [OPC_W-1:0] OP_SORT      = 4'd9;
    localparam logic [OPC_W-1:0] OP_REVERSE   = 4'd10;

    // Response status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] data;
        logic [IDX_W-1:0]        index;
        logic [CNT_W-1:0]        count;
    } rsp_t;

    // Flags from the shared comparator
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/alist_mem.sv @@
// Element store: one write port, one read port with registered read data.
`default_nettype none

module alist_mem #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [AW-1:0]                          waddr,
    input  wire logic signed [alist_pkg::VAL_W-1:0]     wdata,
    input  wire logic [AW-1:0]                          raddr,
    output logic signed [alist_pkg::VAL_W-1:0]          rdata
);

    logic signed [alist_pkg::VAL_W-1:0] store_reg [DEPTH];
    logic signed [alist_pkg::VAL_W-1:0] rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/alist_cmp.sv @@
// Shared comparator: equality and signed greater-than of two elements.
`default_nettype none

module alist_cmp (
    input  wire logic signed [alist_pkg::VAL_W-1:0] a,
    input  wire logic signed [alist_pkg::VAL_W-1:0] b,
    output alist_pkg::cmp_res_t                     res
);

    // Compare both ways in one unit
    always_comb
    begin
        res.eq = (a == b);
        res.gt = (a > b);
    end

endmodule

`default_nettype wire

@@ hw/rtl/alist_seq.sv @@
// Command sequencer: walks the element store through the shared comparator.
`default_nettype none

module alist_seq #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cmd_valid,
    input  wire alist_pkg::cmd_t                    cmd,
    output logic                                    busy,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output alist_pkg::rsp_t                         res,
    output logic                                    mem_we,
    output logic [AW-1:0]                           mem_waddr,
    output logic signed [alist_pkg::VAL_W-1:0]      mem_wdata,
    output logic [AW-1:0]                           mem_raddr,
    input  wire logic signed [alist_pkg::VAL_W-1:0] mem_rdata
);

    localparam int PW = (CW > alist_pkg::POS_W) ? CW : alist_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHR_RD,
        S_SHR_WR,
        S_PUT,
        S_SHL_RD,
        S_SHL_WR,
        S_FETCH,
        S_FETCH_CAP,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_RD_A,
        S_RD_B,
        S_CMP,
        S_SWAP_B,
        S_DONE
    } state_t;

    state_t                             state_reg, state_next;
    logic [alist_pkg::OPC_W-1:0]        op_reg, op_next;
    logic signed [alist_pkg::VAL_W-1:0] val_reg, val_next;
    logic [CW-1:0]                      at_reg, at_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic [CW-1:0]                      pi_reg, pi_next;
    logic [CW-1:0]                      pj_reg, pj_next;
    logic signed [alist_pkg::VAL_W-1:0] hold_reg, hold_next;
    logic                               swp_reg, swp_next;
    logic [alist_pkg::ST_W-1:0]         status_reg, status_next;
    logic signed [alist_pkg::VAL_W-1:0] data_reg, data_next;
    logic [CW-1:0]                      idx_reg, idx_next;

    logic                               accept;
    logic                               full;
    logic                               empty;
    logic [PW-1:0]                      pos_ext;
    logic [PW-1:0]                      cnt_ext;
    logic [CW-1:0]                      pim1;
    logic [CW-1:0]                      pip1;
    logic [CW-1:0]                      pjm1;
    logic [CW-1:0]                      pjp1;
    logic [CW-1:0]                      wptr;
    logic                               do_swap;
    logic signed [alist_pkg::VAL_W-1:0] cmp_a;
    logic signed [alist_pkg::VAL_W-1:0] cmp_b;
    alist_pkg::cmp_res_t                cmp_res;

    // Shared comparator: element against key in search, pair compare in sort
    alist_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign cmp_a = (state_reg == S_CMP) ? hold_reg : mem_rdata;
    assign cmp_b = (state_reg == S_CMP) ? mem_rdata : val_reg;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = cmd_valid && (state_reg == S_IDLE);
    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pos_ext = PW'(cmd.position);
    assign cnt_ext = PW'(cnt_reg);
    assign pim1    = pi_reg - CW'(1);
    assign pip1    = pi_reg + CW'(1);
    assign pjm1    = pj_reg - CW'(1);
    assign pjp1    = pj_reg + CW'(1);
    assign do_swap = (op_reg == alist_pkg::OP_REVERSE) || cmp_res.gt;

    // Response fields
    assign res_valid    = (state_reg == S_DONE);
    assign res.status   = status_reg;
    assign res.data     = data_reg;
    assign res.index    = alist_pkg::IDX_W'(idx_reg);
    assign res.count    = alist_pkg::CNT_W'(cnt_reg);

    // Sequence the store accesses of each command
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        at_next     = at_reg;
        cnt_next    = cnt_reg;
        pi_next     = pi_reg;
        pj_next     = pj_reg;
        hold_next   = hold_reg;
        swp_next    = swp_reg;
        status_next = status_reg;
        data_next   = data_reg;
        idx_next    = idx_reg;
        mem_we      = 1'b0;
        wptr        = pi_reg;
        mem_wdata   = val_reg;
        mem_raddr   = pi_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd.opcode;
                    val_next    = cmd.value;
                    status_next = alist_pkg::ST_OK;
                    data_next   = '0;
                    idx_next    = '0;
                    swp_next    = 1'b0;
                    state_next  = S_DONE;
                    unique case (cmd.opcode)
                        alist_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        alist_pkg::OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = alist_pkg::ST_FULL;
                            end
                            else
                            begin
                                at_next    = cnt_reg;
                                pi_next    = cnt_reg;
                                state_next = S_PUT;
                            end
                        end
                        alist_pkg::OP_INS_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = alist_pkg::ST_FULL;
                            end
                            else
                            begin
                                at_next    = '0;
                                pi_next    = cnt_reg;
                                state_next = empty ? S_PUT : S_SHR_RD;
                            end
                        end
                        alist_pkg::OP_INS_AT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                status_next = alist_pkg::ST_BADPOS;
                            end
                            else if (full)
                            begin
                                status_next = alist_pkg::ST_FULL;
                            end
                            else
                            begin
                                at_next    = CW'(pos_ext);
                                pi_next    = cnt_reg;
                                state_next = (cnt_reg > CW'(pos_ext)) ? S_SHR_RD : S_PUT;
                            end
                        end
                        alist_pkg::OP_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = alist_pkg::ST_EMPTY;
                            end
                            else if (cnt_reg > CW'(1))
                            begin
                                pi_next    = '0;
                                state_next = S_SHL_RD;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        alist_pkg::OP_DEL_END:
                        begin
                            if (empty)
                            begin
                                status_next = alist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        alist_pkg::OP_DEL_AT:
                        begin
                            if (empty)
                            begin
                                status_next = alist_pkg::ST_EMPTY;
                            end
                            else if (pos_ext >= cnt_ext)
                            begin
                                status_next = alist_pkg::ST_BADPOS;
                            end
                            else if ((pos_ext + PW'(1)) < cnt_ext)
                            begin
                                pi_next    = CW'(pos_ext);
                                state_next = S_SHL_RD;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        alist_pkg::OP_READ:
                        begin
                            if (empty)
                            begin
                                status_next = alist_pkg::ST_EMPTY;
                            end
                            else if (pos_ext >= cnt_ext)
                            begin
                                status_next = alist_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                pi_next    = CW'(pos_ext);
                                state_next = S_FETCH;
                            end
                        end
                        alist_pkg::OP_SEARCH:
                        begin
                            if (empty)
                            begin
                                status_next = alist_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                pi_next    = '0;
                                state_next = S_SRCH_RD;
                            end
                        end
                        alist_pkg::OP_SORT:
                        begin
                            if (cnt_reg > CW'(1))
                            begin
                                pi_next    = '0;
                                pj_next    = CW'(1);
                                state_next = S_RD_A;
                            end
                        end
                        alist_pkg::OP_REVERSE:
                        begin
                            if (cnt_reg > CW'(1))
                            begin
                                pi_next    = '0;
                                pj_next    = cnt_reg - CW'(1);
                                state_next = S_RD_A;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Shift right: read the entry below, then move it up one place
            S_SHR_RD:
            begin
                mem_raddr  = pim1[AW-1:0];
                state_next = S_SHR_WR;
            end
            S_SHR_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                pi_next    = pim1;
                state_next = (pim1 > at_reg) ? S_SHR_RD : S_PUT;
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_DONE;
            end

            // Shift left: read the entry above, then move it down one place
            S_SHL_RD:
            begin
                mem_raddr  = pip1[AW-1:0];
                state_next = S_SHL_WR;
            end
            S_SHL_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                pi_next   = pip1;
                if ((pip1 + CW'(1)) < cnt_reg)
                begin
                    state_next = S_SHL_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_FETCH:
            begin
                state_next = S_FETCH_CAP;
            end
            S_FETCH_CAP:
            begin
                data_next  = mem_rdata;
                state_next = S_DONE;
            end

            // Linear search: stop at the first equal entry
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (cmp_res.eq)
                begin
                    status_next = alist_pkg::ST_OK;
                    idx_next    = pi_reg;
                    state_next  = S_DONE;
                end
                else if (pip1 < cnt_reg)
                begin
                    pi_next    = pip1;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    status_next = alist_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end

            // Pair access for sort and reverse
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                mem_raddr  = pj_reg[AW-1:0];
                hold_next  = mem_rdata;
                state_next = S_CMP;
            end
            S_CMP, S_SWAP_B:
            begin
                if ((state_reg == S_CMP) && do_swap)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    swp_next   = 1'b1;
                    state_next = S_SWAP_B;
                end
                else
                begin
                    if (state_reg == S_SWAP_B)
                    begin
                        mem_we    = 1'b1;
                        wptr      = pj_reg;
                        mem_wdata = hold_reg;
                    end
                    // Advance to the next pair, or start another pass
                    if (op_reg == alist_pkg::OP_SORT)
                    begin
                        if (pjp1 < cnt_reg)
                        begin
                            pi_next    = pip1;
                            pj_next    = pjp1;
                            state_next = S_RD_A;
                        end
                        else if (swp_reg)
                        begin
                            pi_next    = '0;
                            pj_next    = CW'(1);
                            swp_next   = 1'b0;
                            state_next = S_RD_A;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        if (pip1 < pjm1)
                        begin
                            pi_next    = pip1;
                            pj_next    = pjm1;
                            state_next = S_RD_A;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            // Hold the response until the output register takes it
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign mem_waddr = wptr[AW-1:0];

    // State and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            swp_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            swp_reg   <= swp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        at_reg     <= at_next;
        pi_reg     <= pi_next;
        pj_reg     <= pj_next;
        hold_reg   <= hold_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        idx_reg    <= idx_next;
    end

    // The count never passes the capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= DEPTH)
        else $error("element count above capacity");

    // No write lands beyond the slot just past the last element
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (wptr <= cnt_reg))
        else $error("store write beyond list end");

    // A new element is placed only when there is room
    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> !full)
        else $error("insert into full list");

    // A search hit points inside the list
    a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (op_reg == alist_pkg::OP_SEARCH) && (status_reg == alist_pkg::ST_OK))
        |-> (idx_reg < cnt_reg))
        else $error("search index outside list");

    // Sort and reverse steps leave the count alone
    a_perm_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CMP) || (state_reg == S_SWAP_B)) |=> $stable(cnt_reg))
        else $error("count changed while permuting");

endmodule

`default_nettype wire

@@ hw/rtl/array_list_engine_top.sv @@
// Top level of the array list engine: sequencer, element store, response register.
//
//  channel  dir  handshake                 payload
//  cmd      in   cmd_valid / cmd_stall     alist_pkg::cmd_t  (opcode, value, position)
//  rsp      out  rsp_valid / rsp_stall     alist_pkg::rsp_t  (status, data, index, count)
//
//  Command steps, each ending with the response loaded into the response register:
//    clear, delete end, errors and unused opcodes answer at once; append writes one entry; read fetches it;
//    insert and delete move each later entry by a read then a write; search reads entries in order;
//    reverse swaps pairs from both ends; sort makes passes until one makes no swap, swapping pairs as needed.
//  The single port pair of the element store paces these steps: one read port and one write port.
//  Reset clears the count and the control state; the store needs no clearing pass.
//  cmd_stall is high while a command is in work; rsp_stall holds the response register.
`default_nettype none

module array_list_engine_top #(
    parameter int DEPTH = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire alist_pkg::cmd_t cmd,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output alist_pkg::rsp_t      rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                               busy;
    logic                               res_valid;
    logic                               res_ready;
    alist_pkg::rsp_t                    res;
    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic signed [alist_pkg::VAL_W-1:0] mem_wdata;
    logic [AW-1:0]                      mem_raddr;
    logic signed [alist_pkg::VAL_W-1:0] mem_rdata;

    logic                               rsp_valid_reg, rsp_valid_next;
    alist_pkg::rsp_t                    rsp_reg;

    alist_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .busy      (busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    alist_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cmd_stall = busy;

    // Load the response register when it is empty or being drained
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ tb/sv/array_list_engine_checker.sv @@
`timescale 1ns / 100ps
// Response checker for the array list engine: predicts each response and compares it.
module array_list_engine_checker #(
    parameter int DEPTH = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire logic            cmd_stall,
    input  wire alist_pkg::cmd_t cmd,
    input  wire logic            rsp_valid,
    input  wire logic            rsp_stall,
    input  wire alist_pkg::rsp_t rsp,
    output int                   fail_count,
    output int                   outstanding
);

    // List contents as the engine should hold them
    logic signed [alist_pkg::VAL_W-1:0] elems [DEPTH];
    int                                 elem_cnt = 0;

    // Responses predicted for accepted commands, oldest first
    alist_pkg::rsp_t predicted_rsp [$];
    alist_pkg::rsp_t oldest;
    int              fail_total = 0;

    // Open a slot at 'at' by moving later entries right, then place v there
    function automatic void place_elem(input int at,
                                       input logic signed [alist_pkg::VAL_W-1:0] v);
        int i;
        for (i = elem_cnt; i > at; i--)
            elems[i] = elems[i-1];
        elems[at] = v;
        elem_cnt++;
    endfunction

    // Close the slot at 'at' by moving later entries left
    function automatic void remove_elem(input int at);
        int i;
        for (i = at; i + 1 < elem_cnt; i++)
            elems[i] = elems[i+1];
        elem_cnt--;
    endfunction

    // Apply one command to the list and return the response it should produce
    function automatic alist_pkg::rsp_t list_response(input alist_pkg::cmd_t c);
        alist_pkg::rsp_t                    r;
        int                                 p;
        int                                 i;
        int                                 j;
        logic                               found;
        logic signed [alist_pkg::VAL_W-1:0] t;
        r = '0;
        r.status = alist_pkg::ST_OK;
        p = int'(c.position);
        found = 1'b0;
        case (c.opcode)
            alist_pkg::OP_CLEAR:
                elem_cnt = 0;
            alist_pkg::OP_APPEND:
                if (elem_cnt >= DEPTH) r.status = alist_pkg::ST_FULL;
                else place_elem(elem_cnt, c.value);
            alist_pkg::OP_INS_FRONT:
                if (elem_cnt >= DEPTH) r.status = alist_pkg::ST_FULL;
                else place_elem(0, c.value);
            alist_pkg::OP_INS_AT:
                // position is checked ahead of the full test
                if (p > elem_cnt) r.status = alist_pkg::ST_BADPOS;
                else if (elem_cnt >= DEPTH) r.status = alist_pkg::ST_FULL;
                else place_elem(p, c.value);
            alist_pkg::OP_DEL_FRONT:
                if (elem_cnt == 0) r.status = alist_pkg::ST_EMPTY;
                else remove_elem(0);
            alist_pkg::OP_DEL_END:
                if (elem_cnt == 0) r.status = alist_pkg::ST_EMPTY;
                else elem_cnt--;
            alist_pkg::OP_DEL_AT:
                if (elem_cnt == 0) r.status = alist_pkg::ST_EMPTY;
                else if (p >= elem_cnt) r.status = alist_pkg::ST_BADPOS;
                else remove_elem(p);
            alist_pkg::OP_READ:
                if (elem_cnt == 0) r.status = alist_pkg::ST_EMPTY;
                else if (p >= elem_cnt) r.status = alist_pkg::ST_BADPOS;
                else r.data = elems[p];
            alist_pkg::OP_SEARCH:
            begin
                r.status = alist_pkg::ST_NOTFOUND;
                for (i = 0; i < elem_cnt; i++)
                begin
                    if (!found && elems[i] == c.value)
                    begin
                        found = 1'b1;
                        r.status = alist_pkg::ST_OK;
                        r.index = alist_pkg::IDX_W'(i);
                    end
                end
            end
            alist_pkg::OP_SORT:
                // ascending, signed compare
                for (i = 0; i < elem_cnt; i++)
                    for (j = 0; j + 1 < elem_cnt; j++)
                        if (elems[j] > elems[j+1])
                        begin
                            t = elems[j];
                            elems[j] = elems[j+1];
                            elems[j+1] = t;
                        end
            alist_pkg::OP_REVERSE:
            begin
                i = 0;
                j = elem_cnt - 1;
                while (i < j)
                begin
                    t = elems[i];
                    elems[i] = elems[j];
                    elems[j] = t;
                    i++;
                    j--;
                end
            end
            default:
                ;
        endcase
        r.count = alist_pkg::CNT_W'(elem_cnt);
        return r;
    endfunction

    // Count a failure, report the first ten in full
    task automatic log_failure(input string what, input alist_pkg::rsp_t want);
        if (fail_total < 10)
            $display("%s at %0t: expected status %0d data %0d index %0d count %0d,",
                     what, $realtime, want.status, want.data, want.index, want.count,
                     " got status %0d data %0d index %0d count %0d",
                     rsp.status, rsp.data, rsp.index, rsp.count);
        fail_total++;
    endtask

    // Check response transactions, then predict command transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            predicted_rsp.delete();
            elem_cnt = 0;
            outstanding <= 0;
        end
        else
        begin
            // compare against the oldest prediction
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_rsp.size() == 0)
                    log_failure("unexpected response", '0);
                else
                begin
                    oldest = predicted_rsp.pop_front();
                    if (oldest.status !== rsp.status || oldest.data !== rsp.data ||
                        oldest.index !== rsp.index || oldest.count !== rsp.count)
                        log_failure("response mismatch", oldest);
                end
            end
            // predict the command just taken
            if (cmd_valid && !cmd_stall)
                predicted_rsp.push_back(list_response(cmd));
            outstanding <= predicted_rsp.size();
            fail_count  <= fail_total;
        end
    end

endmodule

@@ tb/sv/array_list_engine_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the array list engine: clock, reset, command stimulus and verdict.
module array_list_engine_top_tb;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 8000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 64;

    // Opcodes the engine does not define
    localparam logic [alist_pkg::OPC_W-1:0] OP_UNUSED_LO = 4'd11;
    localparam logic [alist_pkg::OPC_W-1:0] OP_UNUSED_HI = 4'd15;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cmd_valid = 1'b0;
    logic            cmd_stall;
    alist_pkg::cmd_t cmd       = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    alist_pkg::rsp_t rsp;
    int              fail_count;
    int              outstanding;

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic long_hold     = 1'b0;
    int   list_len      = 0;
    int   items_sent    = 0;
    int   cycle_count   = 0;
    int   phase;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    array_list_engine_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    array_list_engine_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Stall the response side: long hold-off or random
    always @(posedge clk)
    begin
        rsp_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("array_list_engine_top verification failed");
            $finish;
        end
    end

    // List length after a command, used to steer positions and to bound list growth and the fill and emptying runs
    function automatic int len_after(input logic [alist_pkg::OPC_W-1:0] op,
                                     input int pos, input int len);
        case (op)
            alist_pkg::OP_CLEAR:
                return 0;
            alist_pkg::OP_APPEND, alist_pkg::OP_INS_FRONT:
                return (len < DEPTH) ? len + 1 : len;
            alist_pkg::OP_INS_AT:
                return (pos <= len && len < DEPTH) ? len + 1 : len;
            alist_pkg::OP_DEL_FRONT, alist_pkg::OP_DEL_END:
                return (len > 0) ? len - 1 : len;
            alist_pkg::OP_DEL_AT:
                return (pos < len) ? len - 1 : len;
            default:
                return len;
        endcase
    endfunction

    // Extremes, a small range that makes search hits and sort ties, or anything
    function automatic logic [alist_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return '0;
                    default: return '1;
                endcase
            1, 2, 3: return alist_pkg::VAL_W'(int'($urandom_range(0, 12)) - 6);
            default: return $urandom();
        endcase
    endfunction

    // Mostly in range up to 'limit', sometimes on or just past the edge, sometimes wild
    function automatic logic [alist_pkg::POS_W-1:0] pick_position(input int limit);
        case ($urandom_range(0, 9))
            0:       return alist_pkg::POS_W'($urandom_range(0, 127));
            1:       return alist_pkg::POS_W'(limit + 1);
            2:       return alist_pkg::POS_W'((limit < 0) ? 0 : limit);
            default: return (limit < 0) ? alist_pkg::POS_W'($urandom_range(0, 127))
                                        : alist_pkg::POS_W'($urandom_range(0, limit));
        endcase
    endfunction

    // Offer one command transaction and hold it until taken
    task automatic send_command(input logic [alist_pkg::OPC_W-1:0] op,
                                input logic [alist_pkg::VAL_W-1:0] value,
                                input logic [alist_pkg::POS_W-1:0] pos);
        alist_pkg::cmd_t c;
        c.opcode   = op;
        c.value    = value;
        c.position = pos;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        list_len = len_after(op, int'(pos), list_len);
        items_sent++;
    endtask

    // Drop valid and wait until every response is back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // One random command, weighted toward list edits and lookups
    task automatic send_random_item();
        int                          r;
        logic [alist_pkg::OPC_W-1:0] op;
        logic [alist_pkg::POS_W-1:0] pos;
        r = $urandom_range(0, 99);
        if (r < 2)       op = alist_pkg::OP_CLEAR;
        else if (r < 17) op = alist_pkg::OP_APPEND;
        else if (r < 25) op = alist_pkg::OP_INS_FRONT;
        else if (r < 37) op = alist_pkg::OP_INS_AT;
        else if (r < 45) op = alist_pkg::OP_DEL_FRONT;
        else if (r < 51) op = alist_pkg::OP_DEL_END;
        else if (r < 63) op = alist_pkg::OP_DEL_AT;
        else if (r < 75) op = alist_pkg::OP_READ;
        else if (r < 87) op = alist_pkg::OP_SEARCH;
        else if (r < 90) op = alist_pkg::OP_SORT;
        else if (r < 95) op = alist_pkg::OP_REVERSE;
        else             op = alist_pkg::OPC_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        // keep lists short so sorts stay cheap
        if (list_len > 32 &&
            (op == alist_pkg::OP_APPEND || op == alist_pkg::OP_INS_FRONT ||
             op == alist_pkg::OP_INS_AT) &&
            $urandom_range(0, 1) == 1)
            op = alist_pkg::OP_DEL_AT;
        case (op)
            alist_pkg::OP_INS_AT:
                pos = pick_position(list_len);
            alist_pkg::OP_DEL_AT, alist_pkg::OP_READ:
                pos = pick_position(list_len - 1);
            default:
                pos = alist_pkg::POS_W'($urandom_range(0, 127));
        endcase
        send_command(op, pick_value(), pos);
    endtask

    // Delete down to an empty list, then poke the empty list
    task automatic empty_list();
        while (list_len > 0)
        begin
            case ($urandom_range(0, 2))
                0:       send_command(alist_pkg::OP_DEL_FRONT, pick_value(),
                                      alist_pkg::POS_W'($urandom()));
                1:       send_command(alist_pkg::OP_DEL_END, pick_value(),
                                      alist_pkg::POS_W'($urandom()));
                default: send_command(alist_pkg::OP_DEL_AT, pick_value(),
                                      alist_pkg::POS_W'($urandom_range(0, list_len - 1)));
            endcase
        end
        send_command(alist_pkg::OP_DEL_AT, pick_value(), alist_pkg::POS_W'($urandom()));
        send_command(alist_pkg::OP_READ, pick_value(), alist_pkg::POS_W'($urandom()));
    endtask

    // Insert up to a full list, try the refused inserts, look around, then clear out
    task automatic fill_list();
        int k;
        while (list_len < DEPTH)
        begin
            case ($urandom_range(0, 2))
                0:       send_command(alist_pkg::OP_APPEND, pick_value(),
                                      alist_pkg::POS_W'($urandom()));
                1:       send_command(alist_pkg::OP_INS_FRONT, pick_value(),
                                      alist_pkg::POS_W'($urandom()));
                default: send_command(alist_pkg::OP_INS_AT, pick_value(),
                                      alist_pkg::POS_W'($urandom_range(0, list_len)));
            endcase
        end
        // full list: inserts refused, a position past the count wins over full
        send_command(alist_pkg::OP_APPEND, pick_value(), alist_pkg::POS_W'($urandom()));
        send_command(alist_pkg::OP_INS_FRONT, pick_value(), alist_pkg::POS_W'($urandom()));
        send_command(alist_pkg::OP_INS_AT, pick_value(),
                     alist_pkg::POS_W'($urandom_range(0, DEPTH + 1)));
        for (k = 0; k < 4; k++)
            send_random_item();
        if ($urandom_range(0, 3) == 0)
            send_command(alist_pkg::OP_SORT, pick_value(), alist_pkg::POS_W'($urandom()));
        if ($urandom_range(0, 1) == 1)
            empty_list();
        else
            send_command(alist_pkg::OP_CLEAR, pick_value(), alist_pkg::POS_W'($urandom()));
    endtask

    // Random commands with an occasional fill or emptying run
    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 49))
                0:       fill_list();
                1:       empty_list();
                default: send_random_item();
            endcase
        end
    endtask

    // Empty list, single entry, extremes of value and position, every opcode
    task automatic run_directed();
        send_command(alist_pkg::OP_READ, 32'd0, 7'd0);
        send_command(alist_pkg::OP_DEL_FRONT, 32'd0, 7'd0);
        send_command(alist_pkg::OP_DEL_END, 32'd0, 7'd0);
        send_command(alist_pkg::OP_DEL_AT, 32'd0, 7'd0);
        send_command(alist_pkg::OP_SEARCH, 32'd0, 7'd0);
        send_command(alist_pkg::OP_SORT, 32'd0, 7'd0);
        send_command(alist_pkg::OP_REVERSE, 32'd0, 7'd0);
        send_command(alist_pkg::OP_INS_AT, 32'd7, 7'd1);
        send_command(alist_pkg::OP_INS_AT, 32'h8000_0000, 7'd0);
        send_command(alist_pkg::OP_SORT, 32'd0, 7'd0);
        send_command(alist_pkg::OP_REVERSE, 32'd0, 7'd0);
        send_command(alist_pkg::OP_APPEND, 32'h7fff_ffff, 7'd0);
        send_command(alist_pkg::OP_INS_FRONT, 32'hffff_ffff, 7'd0);
        send_command(alist_pkg::OP_INS_AT, 32'd0, 7'd3);
        send_command(alist_pkg::OP_READ, 32'd0, 7'd3);
        send_command(alist_pkg::OP_READ, 32'd0, 7'd4);
        send_command(alist_pkg::OP_SEARCH, 32'h7fff_ffff, 7'd0);
        send_command(alist_pkg::OP_SEARCH, 32'd5, 7'd0);
        send_command(alist_pkg::OP_SORT, 32'd0, 7'd0);
        send_command(alist_pkg::OP_REVERSE, 32'd0, 7'd0);
        send_command(alist_pkg::OP_DEL_AT, 32'd0, 7'd127);
        send_command(alist_pkg::OP_DEL_AT, 32'd0, 7'd1);
        send_command(alist_pkg::OP_DEL_FRONT, 32'd0, 7'd0);
        send_command(alist_pkg::OP_DEL_END, 32'd0, 7'd0);
        send_command(OP_UNUSED_LO, 32'hffff_ffff, 7'd127);
        send_command(OP_UNUSED_HI, 32'd0, 7'd0);
        send_command(alist_pkg::OP_CLEAR, 32'd0, 7'd0);
    endtask

    // Reset, directed, held-off fill, four idling phases, verdict
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();

        // hold the response side off while a fill keeps coming
        fork
            begin
                long_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold <= 1'b0;
            end
        join_none
        fill_list();
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 72; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            run_random(RANDOM_ITEMS / 4);
            wait_drained();
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("array_list_engine_top verification clean");
        else
            $display("array_list_engine_top verification failed");
        $finish;
    end

endmodule
